### hw/rtl/bsr_pkg.sv
// Shared types and constants for the cubic B-spline table resampler.
// Used by the top level, the weight unit and the port checker; no dependencies.
package bsr_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO  = 2'd2;

	// Field widths
	localparam int SRC_AW   = 8;   // source table address, 256 entries
	localparam int SAMPLE_W = 32;  // signed Q16.16
	localparam int DEST_W   = 12;
	localparam int STEP_W   = 24;  // unsigned Q8.16
	localparam int FRAC_W   = 16;
	localparam int POS_W    = DEST_W + STEP_W;

	localparam logic [SRC_AW-1:0] SOURCE_SIZE_RST = 8'd148;
	localparam logic [DEST_W-1:0] DEST_SIZE_RST   = 12'd4095;
	localparam logic [STEP_W-1:0] STEP_RATIO_RST  = 24'd2369;

	// Input stream packing
	localparam int IN_TDATA_W     = 56;
	localparam int IN_SRC_IDX_LSB = 0;
	localparam int IN_SAMPLE_LSB  = IN_SRC_IDX_LSB + SRC_AW;
	localparam int IN_DEST_LSB    = IN_SAMPLE_LSB + SAMPLE_W;

	// Output stream packing
	localparam int OUT_TDATA_W   = 48;
	localparam int OUT_INDEX_LSB = 0;
	localparam int OUT_VALUE_LSB = OUT_INDEX_LSB + DEST_W;

	// Item kinds carried in the input tuser
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// Blend weights, unsigned Q1.24
	localparam int WEIGHT_W = 25;
	localparam int TAPS     = 4;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef weight_t [TAPS-1:0] weight_vec_t;

endpackage

### hw/rtl/bsr_weights.sv
// Cubic B-spline weight unit: four Q1.24 weights from a 16-bit fraction.
// Four pipeline stages plus a combinational correction; depends on bsr_pkg.
module bsr_weights
	import bsr_pkg::*;
(
	input  logic               clk,
	input  logic [FRAC_W-1:0]  frac,
	output weight_vec_t        weights
);

	localparam int NUM_W = 53;
	localparam logic signed [NUM_W-1:0] CUBE_ONE = 53'sd1 <<< 48;
	// floor(2^27 / 3); the estimate is at most one short of y / 3.
	localparam logic [25:0] DIV3_C = 26'd44739242;

	logic [FRAC_W-1:0]      t_s1, t_s2;
	logic [31:0]            t2_s1, t2_s2;
	logic [47:0]            t3_s2;
	logic signed [NUM_W-1:0] tp_c, t2p_c, t3_c;
	logic signed [NUM_W-1:0] num_c [TAPS];
	logic [25:0]            y_s3 [TAPS];
	logic [25:0]            y_s4 [TAPS];
	logic [24:0]            q0_s4 [TAPS];
	logic [51:0]            prod_c [TAPS];
	logic [26:0]            rem_c [TAPS];

	// Six times each weight, scaled by 2^48, written in powers of t only.
	always_comb begin
		tp_c  = $signed({5'b0, t_s2, 32'b0});
		t2p_c = $signed({5'b0, t2_s2, 16'b0});
		t3_c  = $signed({5'b0, t3_s2});
		num_c[0] = CUBE_ONE - 53'sd3 * tp_c + 53'sd3 * t2p_c - t3_c;
		num_c[1] = 53'sd3 * t3_c - 53'sd6 * t2p_c + 53'sd4 * CUBE_ONE;
		num_c[2] = 53'sd3 * t2p_c + 53'sd3 * tp_c + CUBE_ONE - 53'sd3 * t3_c;
		num_c[3] = t3_c;
		for (int i = 0; i < TAPS; i++) begin
			prod_c[i] = 52'(y_s3[i]) * 52'(DIV3_C);
			rem_c[i]  = 27'(y_s4[i]) - 27'(q0_s4[i]) * 27'd3;
			weights[i] = (rem_c[i] >= 27'd3) ? q0_s4[i] + 25'd1 : q0_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		t_s1  <= frac;
		t2_s1 <= 32'(frac) * 32'(frac);
		t_s2  <= t_s1;
		t2_s2 <= t2_s1;
		t3_s2 <= 48'(t2_s1) * 48'(t_s1);
		for (int i = 0; i < TAPS; i++) begin
			// Dividing by 6 * 2^24 is a shift by 25 and a division by 3.
			y_s3[i]  <= num_c[i][50:25];
			q0_s4[i] <= prod_c[i][51:27];
			y_s4[i]  <= y_s3[i];
		end
	end

endmodule

### hw/rtl/bspline_table_resampler.sv
// A load transaction (tuser 0) writes one source entry and leaves the input ready.
// A compute transaction (tuser 1) is accepted, and the block takes no new item until
// its result reaches the output register, at which point the input is ready again.
// First come the position and selection steps, then the weight state, in which
// the weight pipeline runs and four neighbouring entries are read one a cycle from
// the source memory's read port, followed by the multiply, add and saturate stages.
// A finished result may wait in the output register while the next item is taken.
// The source memory is not cleared: every entry must be loaded before it is used.
// Depends on bsr_pkg and bsr_weights.
module bspline_table_resampler
	import bsr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// source_index [7:0], sample_value [39:8], dest_index [51:40], zero [55:52]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action [0]
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// result_index [11:0], dest_value [43:12], zero [47:44]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status [0]
	output logic                   m_axis_tuser
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_POS  = 7'b0000010,
		ST_SEL  = 7'b0000100,
		ST_WGT  = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_SUM  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		MODE_RANGE = 2'd0,
		MODE_CONST = 2'd1,
		MODE_LIN   = 2'd2,
		MODE_CUB   = 2'd3
	} mode_t;

	localparam logic [2:0]          WGT_LAST = 3'd4;
	localparam weight_t             W_ONE    = 25'h100_0000;
	localparam logic signed [35:0]  SAT_MAX  = 36'sd2147483647;
	localparam logic signed [35:0]  SAT_MIN  = -36'sd2147483648;

	state_t                  state_q;
	logic [2:0]              cnt_q;
	logic [SRC_AW-1:0]       source_size_q;
	logic [DEST_W-1:0]       dest_size_q;
	logic [STEP_W-1:0]       step_ratio_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    fin_go;
	logic                    in_action;
	logic [SRC_AW-1:0]       in_src_idx;
	logic [SAMPLE_W-1:0]     in_sample;
	logic [DEST_W-1:0]       in_dest;

	logic [DEST_W-1:0]       d_q;
	logic [POS_W-1:0]        pos_q;
	mode_t                   mode_q;
	logic [2:0]              n_q;
	logic [SRC_AW-1:0]       base_q;
	logic [FRAC_W-1:0]       t_q;

	mode_t                   mode_c;
	logic [2:0]              n_c;
	logic [SRC_AW-1:0]       base_c;
	logic [19:0]             s_c;
	logic [20:0]             s_inc_c;

	logic [SAMPLE_W-1:0]     src_mem [2**SRC_AW];
	logic                    mem_we;
	logic                    rd_en;
	logic [SRC_AW-1:0]       raddr;
	logic [SAMPLE_W-1:0]     rdata_q;
	logic                    rd_en_s1;
	logic [1:0]              rd_slot_s1;

	weight_vec_t             w_cub;
	weight_vec_t             w_next;
	weight_vec_t             w_q;
	logic signed [SAMPLE_W-1:0] e_q [TAPS];
	logic signed [57:0]      prod_q [TAPS];
	logic signed [58:0]      sum01_q, sum23_q;
	logic signed [59:0]      total_c;
	logic signed [35:0]      shifted_c;
	logic [SAMPLE_W-1:0]     value_c;

	logic                    m_tvalid_q;
	logic [DEST_W-1:0]       out_index_q;
	logic [SAMPLE_W-1:0]     out_value_q;
	logic                    out_status_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign in_action     = s_axis_tuser;
	assign in_src_idx    = s_axis_tdata[IN_SRC_IDX_LSB +: SRC_AW];
	assign in_sample     = s_axis_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
	assign in_dest       = s_axis_tdata[IN_DEST_LSB +: DEST_W];
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign fin_go        = (state_q == ST_FIN) && out_free;

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {4'b0, out_value_q, out_index_q};
	assign m_axis_tuser  = out_status_q;

	// Writes happen only in idle. The read port reads every cycle, but only the reads
	// made while weights are formed are taken into the taps.
	assign mem_we = in_acc && (in_action == ACT_LOAD);
	assign rd_en  = (state_q == ST_WGT) && (cnt_q != WGT_LAST);
	assign raddr  = base_q + SRC_AW'(cnt_q[1:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			src_mem[in_src_idx] <= in_sample;
		end
		rdata_q <= src_mem[raddr];
	end

	// Pick the blend from the destination index and the integer part of the position.
	always_comb begin
		s_c     = pos_q[POS_W-1:FRAC_W];
		s_inc_c = {1'b0, s_c} + 21'd1;
		if (d_q > dest_size_q) begin
			mode_c = MODE_RANGE;
			n_c    = 3'd0;
			base_c = '0;
		end else if (s_c >= 20'(source_size_q)) begin
			mode_c = MODE_CONST;
			n_c    = 3'd1;
			base_c = source_size_q;
		end else if (s_c <= 20'd1 || s_inc_c >= 21'(source_size_q)) begin
			mode_c = MODE_LIN;
			n_c    = 3'd2;
			base_c = s_c[SRC_AW-1:0];
		end else begin
			mode_c = MODE_CUB;
			n_c    = 3'd4;
			base_c = s_c[SRC_AW-1:0] - 8'd1;
		end
	end

	bsr_weights u_weights (
		.clk     (clk),
		.frac    (t_q),
		.weights (w_cub)
	);

	// The linear blend is ((1 - t) * a + t * b) with the same Q1.24 scaling.
	always_comb begin
		w_next = '0;
		case (mode_q)
			MODE_CONST: w_next[0] = W_ONE;
			MODE_LIN: begin
				w_next[0] = {17'h10000 - {1'b0, t_q}, 8'b0};
				w_next[1] = {1'b0, t_q, 8'b0};
			end
			MODE_CUB:   w_next = w_cub;
			default:    w_next = '0;
		endcase
	end

	always_comb begin
		total_c   = 60'(sum01_q) + 60'(sum23_q);
		shifted_c = total_c[59:24];
		if (shifted_c > SAT_MAX) begin
			value_c = 32'h7FFF_FFFF;
		end else if (shifted_c < SAT_MIN) begin
			value_c = 32'h8000_0000;
		end else begin
			value_c = shifted_c[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			rd_en_s1      <= 1'b0;
			m_tvalid_q    <= 1'b0;
			source_size_q <= SOURCE_SIZE_RST;
			dest_size_q   <= DEST_SIZE_RST;
			step_ratio_q  <= STEP_RATIO_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SOURCE_SIZE: source_size_q <= cfg_data[SRC_AW-1:0];
					REG_DEST_SIZE:   dest_size_q   <= cfg_data[DEST_W-1:0];
					REG_STEP_RATIO:  step_ratio_q  <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			rd_en_s1 <= rd_en;
			if (fin_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_action == ACT_COMPUTE) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: state_q <= ST_SEL;
				ST_SEL: begin
					state_q <= ST_WGT;
					cnt_q   <= '0;
				end
				ST_WGT: begin
					if (cnt_q == WGT_LAST) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			d_q <= in_dest;
		end
		if (state_q == ST_POS) begin
			pos_q <= POS_W'(d_q) * POS_W'(step_ratio_q);
		end
		if (state_q == ST_SEL) begin
			mode_q <= mode_c;
			n_q    <= n_c;
			base_q <= base_c;
			t_q    <= pos_q[FRAC_W-1:0];
		end
		rd_slot_s1 <= cnt_q[1:0];
		// Taps the blend does not use are zeroed so that stale entries drop out.
		if (rd_en_s1) begin
			e_q[rd_slot_s1] <= ({1'b0, rd_slot_s1} < n_q) ? rdata_q : '0;
		end
		if (state_q == ST_WGT && cnt_q == WGT_LAST) begin
			w_q <= w_next;
		end
		if (state_q == ST_MUL) begin
			for (int i = 0; i < TAPS; i++) begin
				prod_q[i] <= $signed({1'b0, w_q[i]}) * e_q[i];
			end
		end
		if (state_q == ST_SUM) begin
			sum01_q <= 59'(prod_q[0]) + 59'(prod_q[1]);
			sum23_q <= 59'(prod_q[2]) + 59'(prod_q[3]);
		end
		if (fin_go) begin
			out_index_q  <= d_q;
			out_value_q  <= value_c;
			out_status_q <= (mode_q == MODE_RANGE);
		end
	end

endmodule

### hw/rtl/bsr_checker.sv
// Port-level checks for the resampler, bound to its top level.
// Depends on bsr_pkg and the ports of bspline_table_resampler.
module bsr_checker
	import bsr_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// An out-of-range result carries a zero value.
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		m_axis_tdata[OUT_VALUE_LSB +: SAMPLE_W] == '0)
		else $error("out-of-range result with non-zero value");

	// A compute transaction occupies the block, so the input is not ready next cycle.
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_COMPUTE |=> !s_axis_tready)
		else $error("input ready straight after a compute transaction");

	// A load completes in its own cycle and leaves the input ready.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_LOAD |=> s_axis_tready)
		else $error("input not ready after a load transaction");

endmodule

bind bspline_table_resampler bsr_checker u_bsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/testbench.sv
// Self-checking testbench for bspline_table_resampler: the source table is loaded,
// destination entries are requested, each checked by a local model or a fixed value.
// Depends on bsr_pkg and the resampler RTL.
module testbench
	import bsr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam realtime CLK_HALF = 1ns;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint WEIGHT_DIV = 100663296;	// 6 * 2^24

	typedef struct packed {
		logic                  is_cfg;
		logic                  act;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [SRC_AW-1:0]     src;
		logic [SAMPLE_W-1:0]   sample;
		logic [DEST_W-1:0]     dst;
		logic                  typed;
		logic [SAMPLE_W-1:0]   want_value;
		logic                  want_status;
	} step_row_t;

	typedef struct packed {
		logic [DEST_W-1:0]   idx;
		logic [SAMPLE_W-1:0] value;
		logic                status;
	} dest_entry_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	// Local copy of the block's registers and source memory.
	logic [SRC_AW-1:0] cfg_src_last = SOURCE_SIZE_RST;
	logic [DEST_W-1:0] cfg_dest_last = DEST_SIZE_RST;
	logic [STEP_W-1:0] cfg_step = STEP_RATIO_RST;
	int                src_copy [0:(1 << SRC_AW)-1];

	dest_entry_t pending_results [$];
	step_row_t   script [$];
	step_row_t   cur = '0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;

	bspline_table_resampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic step_row_t row_load(logic [SRC_AW-1:0] idx, logic [SAMPLE_W-1:0] val);
		step_row_t r;
		r = '0;
		r.act = ACT_LOAD;
		r.src = idx;
		r.sample = val;
		return r;
	endfunction

	function automatic step_row_t row_compute(logic [DEST_W-1:0] d);
		step_row_t r;
		r = '0;
		r.act = ACT_COMPUTE;
		r.dst = d;
		return r;
	endfunction

	function automatic step_row_t row_known(logic [DEST_W-1:0] d, logic [SAMPLE_W-1:0] val,
			logic st);
		step_row_t r;
		r = row_compute(d);
		r.typed = 1'b1;
		r.want_value = val;
		r.want_status = st;
		return r;
	endfunction

	function automatic step_row_t row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Destination entry as the block should produce it from the current table copy.
	function automatic dest_entry_t resample_entry(logic [DEST_W-1:0] d);
		dest_entry_t e;
		logic [POS_W-1:0] pos;
		longint s, t, v, q3, w1, w2, w3, w4;
		e.idx = d;
		e.value = '0;
		e.status = 1'b0;
		if (d > cfg_dest_last) begin
			e.status = 1'b1;
			return e;
		end
		pos = d * cfg_step;
		s = longint'(pos[POS_W-1:FRAC_W]);
		t = longint'(pos[FRAC_W-1:0]);
		if (s >= cfg_src_last) begin
			v = longint'(src_copy[cfg_src_last]);
		end else if (s <= 1 || s + 1 >= cfg_src_last) begin
			v = longint'(src_copy[s])
				+ ((t * (longint'(src_copy[s+1]) - longint'(src_copy[s]))) >>> FRAC_W);
		end else begin
			// Weights are Q0.24, each sixfold blend polynomial taken exactly in Q.48 first.
			q3 = 64'sd1 << 48;
			w1 = ((65536 - t) * (65536 - t) * (65536 - t)) / WEIGHT_DIV;
			w2 = (3 * t * t * t - 6 * t * t * 65536 + 4 * q3) / WEIGHT_DIV;
			w3 = (-3 * t * t * t + 3 * t * t * 65536 + 3 * t * 65536 * 65536 + q3) / WEIGHT_DIV;
			w4 = (t * t * t) / WEIGHT_DIV;
			v = (w1 * longint'(src_copy[s-1]) + w2 * longint'(src_copy[s])
				+ w3 * longint'(src_copy[s+1]) + w4 * longint'(src_copy[s+2])) >>> 24;
		end
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		else if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		e.value = v[SAMPLE_W-1:0];
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [DEST_W-1:0] at,
			input logic [SAMPLE_W-1:0] got, input logic [SAMPLE_W-1:0] want);
		$display("result %0d: %s is %h, expected %h", at, what, got, want);
		mismatches++;
	endtask

	// Presents one item after a random gap and returns once the transaction is taken.
	task automatic send_row(input step_row_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		cur = r;
		s_axis_tdata = {{(IN_TDATA_W-IN_DEST_LSB-DEST_W){1'b0}}, r.dst, r.sample, r.src};
		s_axis_tuser = r.act;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Holds the input back until every result is out, then lets the pipeline empty.
	task automatic settle(input int extra);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin : track
		dest_entry_t got, want, known;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SOURCE_SIZE: cfg_src_last = cfg_data[SRC_AW-1:0];
					REG_DEST_SIZE:   cfg_dest_last = cfg_data[DEST_W-1:0];
					REG_STEP_RATIO:  cfg_step = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == ACT_LOAD) begin
					src_copy[s_axis_tdata[IN_SRC_IDX_LSB +: SRC_AW]] =
						s_axis_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
				end else if (cur.typed) begin
					known.idx = s_axis_tdata[IN_DEST_LSB +: DEST_W];
					known.value = cur.want_value;
					known.status = cur.want_status;
					pending_results.push_back(known);
				end else begin
					pending_results.push_back(resample_entry(s_axis_tdata[IN_DEST_LSB +: DEST_W]));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.idx = m_axis_tdata[OUT_INDEX_LSB +: DEST_W];
				got.value = m_axis_tdata[OUT_VALUE_LSB +: SAMPLE_W];
				got.status = m_axis_tuser;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result value", got.idx, got.value, '0);
				end else begin
					want = pending_results.pop_front();
					if (got.idx !== want.idx)
						report_mismatch("result_index", want.idx, SAMPLE_W'(got.idx),
							SAMPLE_W'(want.idx));
					if (got.value !== want.value)
						report_mismatch("dest_value", want.idx, got.value, want.value);
					if (got.status !== want.status)
						report_mismatch("status", want.idx, SAMPLE_W'(got.status),
							SAMPLE_W'(want.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int i, p, n, kind;
		longint est;
		logic [SRC_AW-1:0] ss;
		logic [DEST_W-1:0] ds, d;
		logic [STEP_W-1:0] step;
		logic [SAMPLE_W-1:0] val;

		// Reset configuration: last source entry 148, last destination 4095, step 2369.
		script.push_back(row_load(8'd0,   32'h8000_0000));
		script.push_back(row_load(8'd1,   32'h7fff_ffff));
		script.push_back(row_load(8'd2,   32'h0001_0000));
		script.push_back(row_load(8'd3,   32'hffff_0000));
		script.push_back(row_load(8'd148, 32'h1234_5678));
		script.push_back(row_load(8'd255, 32'hdead_beef));
		script.push_back(row_known(12'd0,    32'h8000_0000, 1'b0));
		script.push_back(row_known(12'd4095, 32'h1234_5678, 1'b0));
		script.push_back(row_compute(12'd28));
		script.push_back(row_compute(12'd56));
		script.push_back(row_compute(12'd2000));
		script.push_back(row_compute(12'd4094));
		script.push_back(row_reg(REG_UNUSED, 24'h000003));
		script.push_back(row_known(12'd4095, 32'h1234_5678, 1'b0));
		// Smallest table: every position is either linear or clamped to the last entry.
		script.push_back(row_reg(REG_SOURCE_SIZE, 24'd3));
		script.push_back(row_reg(REG_DEST_SIZE, 24'd4));
		script.push_back(row_reg(REG_STEP_RATIO, 24'h018000));
		script.push_back(row_known(12'd0,    32'h8000_0000, 1'b0));
		script.push_back(row_compute(12'd1));
		script.push_back(row_known(12'd2,    32'hffff_0000, 1'b0));
		script.push_back(row_known(12'd4,    32'hffff_0000, 1'b0));
		script.push_back(row_known(12'd5,    32'h0000_0000, 1'b1));
		script.push_back(row_known(12'd4095, 32'h0000_0000, 1'b1));
		script.push_back(row_reg(REG_STEP_RATIO, 24'h000000));
		script.push_back(row_known(12'd4,    32'h8000_0000, 1'b0));
		script.push_back(row_reg(REG_SOURCE_SIZE, 24'd255));
		script.push_back(row_reg(REG_DEST_SIZE, 24'd4095));
		script.push_back(row_reg(REG_STEP_RATIO, 24'hffffff));
		script.push_back(row_known(12'd1,    32'hdead_beef, 1'b0));
		script.push_back(row_known(12'd4095, 32'hdead_beef, 1'b0));
		script.push_back(row_reg(REG_STEP_RATIO, 24'h028000));
		script.push_back(row_compute(12'd1));
		script.push_back(row_compute(12'd101));

		send_idle = 36;
		recv_idle = 80;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every source entry is loaded once so that no read ever sees an unwritten entry.
		for (n = 0; n < (1 << SRC_AW); n++)
			send_row(row_load(n[SRC_AW-1:0], $urandom));

		for (i = 0; i < script.size(); i++) begin
			if (script[i].is_cfg) begin
				settle(16);
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_row(script[i]);
			end
		end

		for (p = 0; p < 12; p++) begin
			send_idle = (p < 4) ? 36 : (p < 8) ? 80 : 0;
			recv_idle = (p < 4) ? 80 : (p < 8) ? 36 : 0;
			ss = (p % 4 == 0) ? 8'd3 : (p % 4 == 1) ? 8'd255 : SRC_AW'($urandom_range(3, 255));
			ds = (p % 3 == 0) ? 12'd1 : (p % 3 == 1) ? 12'd4095 : DEST_W'($urandom_range(1, 4095));
			kind = $urandom_range(9);
			if (kind < 7) begin
				// A step near source_size / dest_size spreads positions over the whole table.
				est = (longint'(ss) * 65536) / ds + int'($urandom_range(0, 255)) - 128;
				if (est < 0)
					est = 0;
				if (est > 64'hffffff)
					est = 64'hffffff;
				step = est[STEP_W-1:0];
			end else if (kind == 7) begin
				step = STEP_W'($urandom);
			end else if (kind == 8) begin
				step = '0;
			end else begin
				step = '1;
			end
			settle(16);
			write_reg(REG_SOURCE_SIZE, {{(CFG_DATA_W-SRC_AW){1'b0}}, ss});
			write_reg(REG_DEST_SIZE, {{(CFG_DATA_W-DEST_W){1'b0}}, ds});
			write_reg(REG_STEP_RATIO, step);
			for (n = 0; n < 80; n++) begin
				if ($urandom_range(63) == 0)
					settle(0);
				if ($urandom_range(3) == 0) begin
					kind = $urandom_range(9);
					val = (kind == 0) ? 32'h8000_0000 : (kind == 1) ? 32'h7fff_ffff : $urandom;
					send_row(row_load(SRC_AW'($urandom_range(0, 255)), val));
				end else begin
					kind = $urandom_range(99);
					if (kind < 80)
						d = DEST_W'($urandom_range(0, ds));
					else if (kind < 92 && ds != '1)
						d = DEST_W'($urandom_range(ds + 1, 4095));
					else
						d = DEST_W'($urandom);
					send_row(row_compute(d));
				end
			end
		end

		settle(24);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
